/* rtl/core/kme_pkg.sv */
// ----------------------------------------------------------------------------
// K-mer minimizer extractor package
// Field widths, register indexes, reset values and the cell control group.
// ----------------------------------------------------------------------------
package kme_pkg;

	// Payload field widths
	localparam int CODE_W     = 3;
	localparam int VALUE_W    = 32;
	localparam int START_W    = 24;

	// Configuration register widths and reset values
	localparam int KLEN_W     = 5;
	localparam int WLEN_W     = 6;
	localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd15;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd10;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd1;

	// Run of valid bases, saturating
	localparam int RUN_W = 5;
	localparam logic [RUN_W-1:0] RUN_MAX = 5'd31;

	// Wide enough for any clamp of the window register
	localparam int WCMP_W = 7;

	// Control broadcast to every window cell
	typedef struct packed {
		logic insert;  // a k-mer enters the window this cycle
		logic flush;   // a new read starts: drop every entry first
		logic full;    // no entry leaves: push the oldest out
	} kme_cell_ctl_t;

endpackage

/* rtl/core/kme_if.sv */
// ----------------------------------------------------------------------------
// K-mer minimizer extractor channels
// Base input, minimizer output and configuration write channels.
// ----------------------------------------------------------------------------
interface kme_base_if import kme_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] base_code;
	logic              read_start;

	modport source (output valid, base_code, read_start, input ready);
	modport sink   (input valid, base_code, read_start, output ready);
endinterface

interface kme_min_if import kme_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] minimizer_value;
	logic [START_W-1:0] start_position;

	modport source (output valid, minimizer_value, start_position, input ready);
	modport sink   (input valid, minimizer_value, start_position, output ready);
endinterface

interface kme_cfg_if import kme_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/kme_cell.sv */
// ----------------------------------------------------------------------------
// K-mer minimizer window cell
// Holds one window entry; drops it when stale or larger than the new k-mer
// and moves entries one place up the chain to close gaps.
// ----------------------------------------------------------------------------
module kme_cell import kme_pkg::*; #(
	parameter int VAL_W = 32,
	parameter int POS_W = 24,
	parameter int WIN_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kme_cell_ctl_t    ctl,
	input  logic [VAL_W-1:0] new_value,
	input  logic [POS_W-1:0] cur_pos,
	input  logic [WIN_W-1:0] win_len,
	input  logic             hole_in,
	input  logic             shift_vld,
	input  logic [VAL_W-1:0] shift_value,
	input  logic [POS_W-1:0] shift_pos,
	output logic             vld,
	output logic             keep,
	output logic             hole_out,
	output logic [VAL_W-1:0] value,
	output logic [POS_W-1:0] pos
);

	logic             vld_q;
	logic [VAL_W-1:0] value_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W:0]   reach;
	logic             expired;
	logic             greater;
	logic             shift;

	// Stale once its end position lies a full window back
	assign reach    = {1'b0, pos_q} + (POS_W+1)'(win_len);
	assign expired  = reach <= {1'b0, cur_pos};
	assign greater  = value_q > new_value;
	assign keep     = vld_q & ~ctl.flush & ~expired & ~greater;
	assign hole_out = hole_in | ~keep;
	assign shift    = hole_out | ctl.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.insert) begin
			vld_q <= shift ? shift_vld : keep;
		end else if (ctl.flush) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && shift) begin
			value_q <= shift_value;
			pos_q   <= shift_pos;
		end
	end

	assign vld   = vld_q;
	assign value = value_q;
	assign pos   = pos_q;

endmodule

/* rtl/core/kme_front_sel.sv */
// ----------------------------------------------------------------------------
// K-mer minimizer front select
// Binary tree that finds the valid cell highest in the chain (the oldest entry).
// ----------------------------------------------------------------------------
module kme_front_sel import kme_pkg::*; #(
	parameter int N     = 32,
	parameter int VAL_W = 32,
	parameter int POS_W = 24
) (
	input  logic             vld   [N],
	input  logic [VAL_W-1:0] value [N],
	input  logic [POS_W-1:0] pos   [N],
	output logic             front_vld,
	output logic [VAL_W-1:0] front_value,
	output logic [POS_W-1:0] front_pos
);

	localparam int TREE_N = 2 ** $clog2(N);

	logic             node_vld   [1:2*TREE_N-1];
	logic [VAL_W-1:0] node_value [1:2*TREE_N-1];
	logic [POS_W-1:0] node_pos   [1:2*TREE_N-1];

	for (genvar i = 0; i < TREE_N; i++) begin : g_leaf
		if (i < N) begin : g_used
			assign node_vld[TREE_N+i]   = vld[i];
			assign node_value[TREE_N+i] = value[i];
			assign node_pos[TREE_N+i]   = pos[i];
		end else begin : g_pad
			assign node_vld[TREE_N+i]   = 1'b0;
			assign node_value[TREE_N+i] = '0;
			assign node_pos[TREE_N+i]   = '0;
		end
	end

	// Right child covers higher cells, so it wins when valid
	for (genvar n = 1; n < TREE_N; n++) begin : g_node
		assign node_vld[n]   = node_vld[2*n] | node_vld[2*n+1];
		assign node_value[n] = node_vld[2*n+1] ? node_value[2*n+1] : node_value[2*n];
		assign node_pos[n]   = node_vld[2*n+1] ? node_pos[2*n+1] : node_pos[2*n];
	end

	assign front_vld   = node_vld[1];
	assign front_value = node_value[1];
	assign front_pos   = node_pos[1];

endmodule

/* rtl/core/kmer_minimizer_extractor.sv */
// ----------------------------------------------------------------------------
// K-mer minimizer extractor
// Streams 3-bit coded bases, keeps a rolling k-mer and a monotone window of
// k-mers, and reports each new window minimum with its start position.
// ----------------------------------------------------------------------------
//
//   channel    | dir | payload                           | accepted when
//   -----------+-----+-----------------------------------+---------------------
//   base       | in  | base_code[2:0], read_start        | valid && ready
//   minimizer  | out | minimizer_value[31:0],            | valid && ready
//              |     | start_position[23:0]              |
//   cfg        | in  | index[1:0], data[7:0]             | valid (ready is high)
//
// One base is taken per cycle while results are drained. The request that
// causes a result first updates the cell chain; the oldest live cell is then
// picked and the result registered.
// When a result waits in the output register and the check stage holds the
// next one, base ready drops until the output is taken.
// Reset leaves no clearing pass: each cell has its own valid flop.
// ----------------------------------------------------------------------------
module kmer_minimizer_extractor import kme_pkg::*; #(
	parameter int MAX_WINDOW    = 32,
	parameter int MAX_KMER      = 16,
	parameter int POSITION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	kme_base_if.sink    base,
	kme_min_if.source   minimizer,
	kme_cfg_if.sink     cfg
);

	localparam int KB = 2 * MAX_KMER;                   // packed k-mer bits
	localparam int P  = POSITION_BITS;
	localparam int WW = $clog2(MAX_WINDOW + 1);         // clamped window width

	// ---------------------------------------------------------------- config
	logic [KLEN_W-1:0] kmer_len_q;
	logic [WLEN_W-1:0] win_len_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q <= KLEN_RESET;
			win_len_q  <= WLEN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_KMER_LEN:   kmer_len_q <= cfg.data[KLEN_W-1:0];
				CFG_WINDOW_LEN: win_len_q  <= cfg.data[WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp k to 1..MAX_KMER and w to 1..MAX_WINDOW
	logic [KLEN_W-1:0] k_eff;
	logic [WCMP_W-1:0] w_wide;
	logic [WCMP_W-1:0] w_clamp;
	logic [WW-1:0]     w_eff;

	assign k_eff = (kmer_len_q == '0) ? KLEN_W'(1) :
	               (kmer_len_q > KLEN_W'(MAX_KMER)) ? KLEN_W'(MAX_KMER) : kmer_len_q;
	assign w_wide  = WCMP_W'(win_len_q);
	assign w_clamp = (w_wide == '0) ? WCMP_W'(1) :
	                 (w_wide > WCMP_W'(MAX_WINDOW)) ? WCMP_W'(MAX_WINDOW) : w_wide;
	assign w_eff   = w_clamp[WW-1:0];

	// ------------------------------------------------------- front-end state
	logic [KB-1:0]    roll_q;
	logic [P-1:0]     pos_q;
	logic [RUN_W-1:0] run_q;
	logic [WW-1:0]    seen_q;

	logic             base_acc;
	logic             flush;
	logic             is_n;
	logic [KB-1:0]    roll_base;
	logic [KB-1:0]    roll_new;
	logic [KB-1:0]    kmask;
	logic [P-1:0]     pos_base;
	logic [P-1:0]     pos_next;
	logic [RUN_W-1:0] run_base;
	logic [RUN_W-1:0] run_new;
	logic [WW-1:0]    seen_base;
	logic [WW-1:0]    seen_new;
	logic             insert;
	logic             check;

	assign base_acc = base.valid & base.ready;
	assign flush    = base.read_start;
	assign is_n     = base.base_code[CODE_W-1];

	// A read start clears everything before this base is taken
	assign roll_base = flush ? '0 : roll_q;
	assign pos_base  = flush ? '0 : pos_q;
	assign run_base  = flush ? '0 : run_q;
	assign seen_base = flush ? '0 : seen_q;

	assign kmask    = ~({KB{1'b1}} << {k_eff, 1'b0});
	assign roll_new = ((roll_base << 2) | KB'(base.base_code[1:0])) & kmask;
	assign pos_next = (pos_base == '1) ? pos_base : pos_base + P'(1);
	assign run_new  = is_n ? '0 : (run_base == RUN_MAX) ? run_base : run_base + RUN_W'(1);
	assign insert   = ~is_n & (run_new >= k_eff);
	assign seen_new = (seen_base < w_eff) ? seen_base + WW'(1) : seen_base;
	assign check    = insert & (seen_new >= w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q <= '0;
			pos_q  <= '0;
			run_q  <= '0;
			seen_q <= '0;
		end else if (base_acc) begin
			pos_q <= pos_next;
			run_q <= run_new;
			// An N keeps the rolling k-mer and the k-mer count
			roll_q <= is_n ? roll_base : roll_new;
			seen_q <= insert ? seen_new : seen_base;
		end
	end

	// ------------------------------------------------------------ cell chain
	// Cell 0 takes the newest k-mer; older entries sit higher. A gap anywhere
	// above a cell makes it move up by one; with no gap the top entry is
	// pushed out.
	kme_cell_ctl_t   cell_ctl;
	logic            cell_vld   [MAX_WINDOW];
	logic            cell_keep  [MAX_WINDOW];
	logic [KB-1:0]   cell_value [MAX_WINDOW];
	logic [P-1:0]    cell_pos   [MAX_WINDOW];
	logic            hole       [MAX_WINDOW+1];

	assign hole[MAX_WINDOW] = 1'b0;
	assign cell_ctl.insert  = base_acc & insert;
	assign cell_ctl.flush   = base_acc & flush;
	assign cell_ctl.full    = ~hole[0];

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic          sh_vld;
		logic [KB-1:0] sh_value;
		logic [P-1:0]  sh_pos;

		if (i == 0) begin : g_head
			assign sh_vld   = 1'b1;
			assign sh_value = roll_new;
			assign sh_pos   = pos_base;
		end else begin : g_body
			assign sh_vld   = cell_keep[i-1];
			assign sh_value = cell_value[i-1];
			assign sh_pos   = cell_pos[i-1];
		end

		kme_cell #(
			.VAL_W (KB),
			.POS_W (P),
			.WIN_W (WW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (cell_ctl),
			.new_value   (roll_new),
			.cur_pos     (pos_base),
			.win_len     (w_eff),
			.hole_in     (hole[i+1]),
			.shift_vld   (sh_vld),
			.shift_value (sh_value),
			.shift_pos   (sh_pos),
			.vld         (cell_vld[i]),
			.keep        (cell_keep[i]),
			.hole_out    (hole[i]),
			.value       (cell_value[i]),
			.pos         (cell_pos[i])
		);
	end

	// ----------------------------------------------------------- check stage
	logic              chk_vld_s1;
	logic [KLEN_W-1:0] chk_k_s1;
	logic              chk_adv;
	logic              out_vld_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [START_W-1:0] out_start_q;
	logic              emitted_q;
	logic [P-1:0]      last_start_q;

	logic              front_vld;
	logic [KB-1:0]     front_value;
	logic [P-1:0]      front_pos;
	logic [P-1:0]      start;
	logic              emit;
	logic [VALUE_W+KB-1:0] value_ext;
	logic [START_W+P-1:0]  start_ext;

	kme_front_sel #(
		.N     (MAX_WINDOW),
		.VAL_W (KB),
		.POS_W (P)
	) u_front (
		.vld         (cell_vld),
		.value       (cell_value),
		.pos         (cell_pos),
		.front_vld   (front_vld),
		.front_value (front_value),
		.front_pos   (front_pos)
	);

	// Cells already show the state left by the request in the check stage
	assign start     = front_pos - P'(chk_k_s1) + P'(1);
	assign emit      = front_vld & (~emitted_q | (start != last_start_q));
	assign value_ext = {{VALUE_W{1'b0}}, front_value};
	assign start_ext = {{START_W{1'b0}}, start};

	assign chk_adv    = chk_vld_s1 & (~out_vld_q | minimizer.ready);
	assign base.ready = ~chk_vld_s1 | chk_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
			emitted_q  <= 1'b0;
		end else begin
			if (base_acc) begin
				chk_vld_s1 <= check;
			end else if (chk_adv) begin
				chk_vld_s1 <= 1'b0;
			end

			if (chk_adv) begin
				out_vld_q <= emit;
			end else if (minimizer.ready) begin
				out_vld_q <= 1'b0;
			end

			// A new read forgets the last start; it wins over an older result
			if (base_acc && flush) begin
				emitted_q <= 1'b0;
			end else if (chk_adv && emit) begin
				emitted_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (base_acc) begin
			chk_k_s1 <= k_eff;
		end
		if (chk_adv && emit) begin
			last_start_q <= start;
			out_value_q  <= value_ext[VALUE_W-1:0];
			out_start_q  <= start_ext[START_W-1:0];
		end
	end

	assign minimizer.valid           = out_vld_q;
	assign minimizer.minimizer_value = out_value_q;
	assign minimizer.start_position  = out_start_q;

endmodule

/* rtl/core/kme_checker.sv */
// ----------------------------------------------------------------------------
// K-mer minimizer extractor checker
// Port-level checks on result timing and output handshake.
// ----------------------------------------------------------------------------
module kme_checker import kme_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               base_valid,
	input  logic               base_ready,
	input  logic [CODE_W-1:0]  base_code,
	input  logic               min_valid,
	input  logic               min_ready,
	input  logic [VALUE_W-1:0] min_value,
	input  logic [START_W-1:0] min_start
);

	logic base_acc;

	assign base_acc = base_valid & base_ready;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		min_valid && !min_ready |=> min_valid)
		else $error("result dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		min_valid && !min_ready |=> $stable(min_value) && $stable(min_start))
		else $error("result changed while stalled");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(min_valid) |-> $past(base_acc, 2) && !$past(base_code[CODE_W-1], 2))
		else $error("result without a valid base two cycles back");

	a_known_payload: assert property (@(posedge clk) disable iff (!arst_n)
		min_valid |-> !$isunknown({min_value, min_start}))
		else $error("result payload unknown while valid");

endmodule

bind kmer_minimizer_extractor kme_checker u_kme_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.base_valid (base.valid),
	.base_ready (base.ready),
	.base_code  (base.base_code),
	.min_valid  (minimizer.valid),
	.min_ready  (minimizer.ready),
	.min_value  (minimizer.minimizer_value),
	.min_start  (minimizer.start_position)
);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// K-mer minimizer extractor testbench
// Streams bases into the extractor through the base channel and predicts
// every minimizer with a cycle-free window model kept beside the block. The
// run covers the register reset values, directed corner cases and random
// reads under several register settings and three back-pressure profiles.
// ----------------------------------------------------------------------------
module tb_top;
	import kme_pkg::*;

	localparam int WIN_DEPTH = 32;
	localparam int KMER_MAX  = 16;
	localparam int RUN_SAT   = 31;
	localparam logic [START_W-1:0] POS_LAST = '1;
	localparam int REPORT_CAP = 200;

	// Register indexes that map to no register
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	// Base codes; anything from BASE_N upward reads as N
	typedef enum logic [CODE_W-1:0] {
		BASE_A     = 3'd0,
		BASE_C     = 3'd1,
		BASE_G     = 3'd2,
		BASE_T     = 3'd3,
		BASE_N     = 3'd4,
		BASE_N_TOP = 3'd7
	} base_code_e;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [START_W-1:0] start;
	} minimizer_t;

	logic clk;
	logic arst_n;

	kme_base_if base_ch ();
	kme_min_if  min_ch ();
	kme_cfg_if  cfg_ch ();

	kmer_minimizer_extractor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.base      (base_ch),
		.minimizer (min_ch),
		.cfg       (cfg_ch)
	);

	// Back-pressure profile, in percent of cycles spent idle
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	int unsigned mismatch_count;
	int unsigned bases_sent;
	int unsigned reg_writes;
	int unsigned minimizers_checked;

	// Window model: register copies, read state and the monotone window
	logic [KLEN_W-1:0]  kmer_len_reg;
	logic [WLEN_W-1:0]  win_len_reg;
	logic [63:0]        roll_kmer;
	logic [START_W-1:0] pos_cursor;
	int unsigned        run_len;
	int unsigned        kmers_in;
	logic [VALUE_W-1:0] win_val [WIN_DEPTH];
	logic [START_W-1:0] win_pos [WIN_DEPTH];
	int unsigned        win_head;
	int unsigned        win_cnt;
	bit                 have_emitted;
	logic [START_W-1:0] last_start;

	minimizer_t pending_minimizers[$];

	always #5 clk = ~clk;

	// Bound the whole run
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		// keep the log readable if the block goes badly wrong
		if (mismatch_count <= REPORT_CAP)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic int unsigned clamp_k(input logic [KLEN_W-1:0] raw);
		if (raw < 1) return 1;
		if (raw > KMER_MAX) return KMER_MAX;
		return raw;
	endfunction

	function automatic int unsigned clamp_w(input logic [WLEN_W-1:0] raw);
		if (raw < 1) return 1;
		if (raw > WIN_DEPTH) return WIN_DEPTH;
		return raw;
	endfunction

	function automatic void clear_read();
		roll_kmer    = '0;
		pos_cursor   = '0;
		run_len      = 0;
		kmers_in     = 0;
		win_head     = 0;
		win_cnt      = 0;
		have_emitted = 1'b0;
		last_start   = '0;
	endfunction

	// Advance the window model by one accepted base and queue the minimizer
	// it reports, if any.
	function automatic void advance_window(input logic [CODE_W-1:0] code, input logic rs);
		int unsigned        k;
		int unsigned        w;
		logic [START_W-1:0] pos;
		logic [63:0]        kmask;
		minimizer_t         m;
		if (rs)
			clear_read();
		k   = clamp_k(kmer_len_reg);
		w   = clamp_w(win_len_reg);
		pos = pos_cursor;
		if (pos_cursor != POS_LAST)
			pos_cursor++;
		// N breaks the run but keeps the window and the k-mer count
		if (code >= BASE_N) begin
			run_len = 0;
			return;
		end
		kmask     = (64'd1 << (2 * k)) - 64'd1;
		roll_kmer = ((roll_kmer << 2) | 64'(code)) & kmask;
		if (run_len < RUN_SAT)
			run_len++;
		if (run_len < k)
			return;
		// drop entries that slid out of the window
		while (win_cnt > 0 && 64'(win_pos[win_head]) + 64'(w) <= 64'(pos)) begin
			win_head = (win_head + 1) % WIN_DEPTH;
			win_cnt--;
		end
		// drop strictly larger entries from the back; an equal one stays older
		while (win_cnt > 0 &&
		       64'(win_val[(win_head + win_cnt - 1) % WIN_DEPTH]) > roll_kmer)
			win_cnt--;
		if (win_cnt >= WIN_DEPTH) begin
			win_head = (win_head + 1) % WIN_DEPTH;
			win_cnt--;
		end
		win_val[(win_head + win_cnt) % WIN_DEPTH] = roll_kmer[VALUE_W-1:0];
		win_pos[(win_head + win_cnt) % WIN_DEPTH] = pos;
		win_cnt++;
		if (kmers_in < w)
			kmers_in++;
		if (kmers_in < w)
			return;
		// start wraps modulo the position width when k grew mid-read
		m.start = win_pos[win_head] - START_W'(k) + START_W'(1);
		m.value = win_val[win_head];
		if (have_emitted && m.start == last_start)
			return;
		have_emitted = 1'b1;
		last_start   = m.start;
		pending_minimizers = {pending_minimizers, m};
	endfunction

	// Send one base request; entered and left at a falling edge
	task automatic send_base(input logic [CODE_W-1:0] code, input logic rs);
		while ($urandom_range(99) < send_idle_pct) begin
			base_ch.valid <= 1'b0;
			@(negedge clk);
		end
		base_ch.valid      <= 1'b1;
		base_ch.base_code  <= code;
		base_ch.read_start <= rs;
		do @(posedge clk); while (!base_ch.ready);
		advance_window(code, rs);
		bases_sent++;
		@(negedge clk);
	endtask

	// Write one configuration register; only called while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == CFG_KMER_LEN)
			kmer_len_reg = data[KLEN_W-1:0];
		else if (idx == CFG_WINDOW_LEN)
			win_len_reg = data[WLEN_W-1:0];
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Drop base valid, drain all pending minimizers, then let the two-stage
	// pipe settle so a trailing N or silent base is fully absorbed.
	task automatic drain_block();
		base_ch.valid <= 1'b0;
		while (pending_minimizers.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Random reads: mostly clean reads from their first base, some over a
	// two-letter alphabet to force equal k-mers, and a few noisy ones with
	// random N codes and stray read starts.
	task automatic run_reads(input int unsigned n_items);
		int unsigned        sent;
		int unsigned        len;
		int unsigned        i;
		bit                 narrow;
		bit                 noisy;
		logic [CODE_W-1:0]  code;
		logic               rs;
		sent = 0;
		while (sent < n_items) begin
			len    = $urandom_range(clamp_k(kmer_len_reg) + clamp_w(win_len_reg) + 24, 1);
			narrow = ($urandom_range(3) == 0);
			noisy  = ($urandom_range(9) == 0);
			for (i = 0; i < len && sent < n_items; i++) begin
				if (noisy) begin
					code = CODE_W'($urandom_range(7));
					rs   = ($urandom_range(15) == 0);
				end else begin
					if ($urandom_range(99) < 6)
						code = CODE_W'($urandom_range(7, BASE_N));
					else if (narrow)
						code = CODE_W'($urandom_range(BASE_C));
					else
						code = CODE_W'($urandom_range(BASE_T));
					rs = (i == 0);
				end
				send_base(code, rs);
				sent++;
			end
		end
	endtask

	// Reads under the register reset values, before any write
	task automatic test_reset_registers();
		run_reads(60);
		drain_block();
	endtask

	// Lowest k and w: every valid base reports itself; N bases and a new read
	// mid-stream; unused register indexes and high data bits ignored.
	task automatic test_single_base_window();
		write_reg(CFG_KMER_LEN, 8'hE1);
		write_reg(CFG_WINDOW_LEN, 8'hC1);
		write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(255)));
		write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(255)));
		send_base(BASE_A, 1'b1);
		send_base(BASE_C, 1'b0);
		send_base(BASE_G, 1'b0);
		send_base(BASE_T, 1'b0);
		send_base(BASE_N, 1'b0);
		send_base(BASE_A, 1'b0);
		send_base(BASE_N_TOP, 1'b0);
		send_base(BASE_C, 1'b1);
		send_base(BASE_T, 1'b0);
		drain_block();
	endtask

	// Equal k-mers: the oldest stays the minimum until it leaves the window
	task automatic test_tie_oldest();
		write_reg(CFG_WINDOW_LEN, 8'd3);
		send_base(BASE_A, 1'b1);
		send_base(BASE_A, 1'b0);
		send_base(BASE_A, 1'b0);
		send_base(BASE_A, 1'b0);
		send_base(BASE_A, 1'b0);
		send_base(BASE_C, 1'b0);
		drain_block();
	endtask

	// Grow k mid-read while the window front sits at position 0: the start
	// position wraps below zero.
	task automatic test_kmer_growth_mid_read();
		int unsigned i;
		write_reg(CFG_KMER_LEN, 8'd1);
		write_reg(CFG_WINDOW_LEN, 8'd16);
		send_base(BASE_A, 1'b1);
		for (i = 1; i < 15; i++)
			send_base(BASE_A, 1'b0);
		drain_block();
		write_reg(CFG_KMER_LEN, 8'd16);
		send_base(BASE_A, 1'b0);
		drain_block();
	endtask

	// Three back-pressure profiles, three register settings each; a negative
	// entry picks a random raw register value.
	task automatic test_random_traffic();
		int          k_raw [9];
		int          w_raw [9];
		int unsigned ph;
		int unsigned seg;
		int          kv;
		int          wv;
		k_raw = '{3, 0, 16, 31, 1, -1, 5, -1, 20};
		w_raw = '{4, 0, 32, 63, 1, -1, 12, -1, 40};
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 15; recv_idle_pct = 85; end
				1: begin send_idle_pct = 85; recv_idle_pct = 15; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (seg = 0; seg < 3; seg++) begin
				kv = k_raw[ph * 3 + seg];
				wv = w_raw[ph * 3 + seg];
				if (kv < 0) kv = $urandom_range(31);
				if (wv < 0) wv = $urandom_range(63);
				write_reg(CFG_KMER_LEN, {3'($urandom_range(7)), KLEN_W'(kv)});
				write_reg(CFG_WINDOW_LEN, {2'($urandom_range(3)), WLEN_W'(wv)});
				run_reads(88);
				drain_block();
			end
		end
	endtask

	// Hold the minimizer channel back at random, per the active profile
	always @(negedge clk)
		min_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	// Compare every accepted minimizer with the oldest prediction
	always @(posedge clk) begin : check_minimizer
		minimizer_t want;
		if (arst_n && min_ch.valid && min_ch.ready) begin
			if (pending_minimizers.size() == 0) begin
				report_mismatch($sformatf("unexpected minimizer %h start %0d",
					min_ch.minimizer_value, min_ch.start_position));
			end else begin
				want = pending_minimizers[0];
				pending_minimizers.delete(0);
				if (min_ch.minimizer_value !== want.value)
					report_mismatch($sformatf("minimizer value %h, predicted %h",
						min_ch.minimizer_value, want.value));
				if (min_ch.start_position !== want.start)
					report_mismatch($sformatf("start position %0d, predicted %0d",
						min_ch.start_position, want.start));
				minimizers_checked++;
			end
		end
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		base_ch.valid      = 1'b0;
		base_ch.base_code  = '0;
		base_ch.read_start = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;
		min_ch.ready       = 1'b0;
		send_idle_pct      = 15;
		recv_idle_pct      = 85;
		mismatch_count     = 0;
		bases_sent         = 0;
		reg_writes         = 0;
		minimizers_checked = 0;
		kmer_len_reg       = KLEN_RESET;
		win_len_reg        = WLEN_RESET;
		clear_read();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_registers();
		test_single_base_window();
		test_tie_oldest();
		test_kmer_growth_mid_read();
		test_random_traffic();

		// catch any stray minimizer after the last prediction
		drain_block();
		repeat (10) @(negedge clk);
		if (pending_minimizers.size() != 0)
			report_mismatch($sformatf("%0d predicted minimizers never arrived",
				pending_minimizers.size()));

		$display("Run covered %0d bases and %0d register writes over three back-pressure profiles",
			bases_sent, reg_writes);
		$display("%0d minimizers compared, %0d mismatches", minimizers_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
